// ----- rtl/core/lru_page_cache_core_assert.svh -----
// Assertion macros used by the page cache core.
`ifndef LRU_PAGE_CACHE_CORE_ASSERT_SVH
`define LRU_PAGE_CACHE_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define LPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page cache check failed");

// Check that cons holds in the cycle after ante.
`define LPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page cache check failed");

`endif

// ----- rtl/core/lpc_pkg.sv -----
// Shared constants and types of the LRU page cache.
`default_nettype none

package lpc_pkg;

  // Capacity register width and its value after reset
  localparam int unsigned CapW     = 5;
  localparam int unsigned CapReset = 16;

  typedef logic [CapW-1:0] cap_t;

endpackage

`default_nettype wire

// ----- rtl/core/lru_page_cache_core.sv -----
// Fully associative LRU page directory with one lookup per cycle while m_axis is not stalled.
//
//   channel   dir  data layout (low bit first)                          handshake
//   s_axis    in   page_number[PAGE_BITS], zero pad to bytes             tvalid/tready
//   m_axis    out  hit, evicted_valid, evicted_page, occupancy, pad      tvalid/tready
//   cfg       in   capacity[5]                                          cfg_we_i strobe
//
// One transfer per cycle unless m_axis stalls: a page waits in the input register, then the
// parallel tag compare, victim select and rank update write the store and the
// result register at the same edge, so the next page sees the updated order.
// Result valid rises when the input register advances into the result register.
// Reset and any capacity write empty the store at once; no clearing pass.
// A stalled result register holds the input register, which then holds s_axis.
`default_nettype none

module lru_page_cache_core
  import lpc_pkg::*;
#(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned PAGE_BITS = 20,
  localparam int unsigned CntW     = $clog2(ENTRIES + 1),
  localparam int unsigned InW      = ((PAGE_BITS + 7) / 8) * 8,
  localparam int unsigned OutW     = ((2 + PAGE_BITS + CntW + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // configuration
  input  wire logic            cfg_we_i,
  input  wire cap_t            cfg_wdata_i,   // capacity
  // input stream
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [InW-1:0]  s_axis_tdata,  // page_number, pad
  // result stream
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [OutW-1:0]      m_axis_tdata   // hit, evicted_valid, evicted_page, occupancy, pad
);

  localparam int unsigned RankW   = $clog2(ENTRIES);
  localparam int unsigned CmpW    = (CntW > CapW) ? CntW : CapW;
  localparam int unsigned CapRst  = (CapReset > ENTRIES) ? ENTRIES : CapReset;

  typedef logic [RankW-1:0]     rank_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [CntW-1:0]      cnt_t;

  // Store
  page_t              tag_q   [ENTRIES];
  page_t              tag_d   [ENTRIES];
  rank_t              rank_q  [ENTRIES];
  rank_t              rank_d  [ENTRIES];
  logic [ENTRIES-1:0] valid_q, valid_d;
  cnt_t               count_q, count_d;
  cnt_t               cap_q, cap_d;

  // Input register
  logic  in_vld_q;
  page_t in_page_q;

  // Result register
  logic  out_vld_q;
  logic  out_hit_q, out_hit_d;
  logic  out_ev_q, out_ev_d;
  page_t out_evpage_q, out_evpage_d;
  cnt_t  out_occ_q;

  // Lookup terms
  logic [ENTRIES-1:0] match, victim, valid_left, free_oh;
  rank_t              hit_rank, last_rank;
  logic               any_free;
  logic               advance;

  // Move the input register forward when the result register can take it
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  // Clamp a written capacity into 1 .. ENTRIES
  always_comb begin
    cap_d = CntW'(CmpW'(cfg_wdata_i));
    if (cfg_wdata_i == '0) begin
      cap_d = CntW'(1);
    end else if (CmpW'(cfg_wdata_i) > CmpW'(ENTRIES)) begin
      cap_d = CntW'(ENTRIES);
    end
  end

  // Compare the page against all entries and pick hit rank and victim
  assign last_rank = RankW'(count_q - CntW'(1));

  always_comb begin
    hit_rank     = '0;
    out_evpage_d = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_q[i] && (tag_q[i] == in_page_q);
      victim[i] = valid_q[i] && (rank_q[i] == last_rank);
      hit_rank  = hit_rank | (match[i] ? rank_q[i] : '0);
    end
    out_hit_d = |match;
    out_ev_d  = !out_hit_d && (count_q >= cap_q) && (|victim);
    for (int i = 0; i < ENTRIES; i++) begin
      out_evpage_d = out_evpage_d | ((out_ev_d && victim[i]) ? tag_q[i] : '0);
    end
  end

  // Drop the victim and find the lowest free slot
  assign valid_left = valid_q & ~(out_ev_d ? victim : '0);
  assign free_oh    = ~valid_left & (valid_left + ENTRIES'(1));
  assign any_free   = |free_oh;

  // Update tags, valid bits, ranks and count
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < ENTRIES; i++) begin
      tag_d[i]  = tag_q[i];
      rank_d[i] = rank_q[i];
    end
    if (advance) begin
      if (out_hit_d) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_d[i] = rank_q[i] + RankW'(1);
          end
        end
      end else begin
        valid_d = valid_left | free_oh;
        count_d = count_q - CntW'(out_ev_d) + CntW'(any_free);
        for (int i = 0; i < ENTRIES; i++) begin
          if (free_oh[i]) begin
            tag_d[i]  = in_page_q;
            rank_d[i] = '0;
          end else if (valid_left[i]) begin
            rank_d[i] = rank_q[i] + RankW'(1);
          end
        end
      end
    end
  end

  // Hold control state; a capacity write empties the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      cap_q   <= CntW'(CapRst);
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      valid_q <= '0;
      count_q <= '0;
      cap_q   <= cap_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Tags need no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      tag_q[i] <= tag_d[i];
    end
  end

  // Input register: take a transfer whenever there is room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_page_q <= s_axis_tdata[PAGE_BITS-1:0];
    end
  end

  // Result register: load on advance, drop after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hit_q    <= out_hit_d;
      out_ev_q     <= out_ev_d;
      out_evpage_q <= out_evpage_d;
      out_occ_q    <= count_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutW'({out_occ_q, out_evpage_q, out_ev_q, out_hit_q});

  // Checks
  `include "lru_page_cache_core_assert.svh"

  `LPC_ASSERT_SAME(a_count_matches_valid, clk_i, rst_ni, 1'b1, $countones(valid_q) == count_q)
  `LPC_ASSERT_SAME(a_count_within_cap, clk_i, rst_ni, 1'b1, count_q <= cap_q)
  `LPC_ASSERT_SAME(a_hit_no_evict, clk_i, rst_ni, out_vld_q, !(out_hit_q && out_ev_q))
  `LPC_ASSERT_NEXT(a_hit_keeps_count, clk_i, rst_ni, advance && out_hit_d && !cfg_we_i, count_q == $past(count_q))

endmodule

`default_nettype wire
